FILE: design/gda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gda_pkg;

	// Width of the day count; everything below follows from it.
	localparam int ADD_BITS = 20;

	// Running ordinal: count plus an ordinal of at most 366.
	localparam int T_W   = ((ADD_BITS > 9) ? ADD_BITS : 9) + 1;
	// Shared unit width: wide enough for the ordinal and for a 14-bit year.
	localparam int ALU_W = (T_W > 14) ? T_W : 14;
	// Exact year: start year plus fewer than 2**(ADD_BITS-8) whole years.
	localparam int Y_W   = (((ADD_BITS - 8) > 14) ? (ADD_BITS - 8) : 14) + 1;

	localparam logic [8:0] CYCLE_YEARS = 9'd400;
	localparam logic [8:0] LAST_RES    = 9'd399;
	localparam logic [8:0] LEN_LEAP    = 9'd366;
	localparam logic [8:0] LEN_COMMON  = 9'd365;
	localparam logic [3:0] MONTH_JAN   = 4'd1;
	localparam logic [3:0] MONTH_FEB   = 4'd2;
	localparam logic [3:0] MONTH_DEC   = 4'd12;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             borrow;
		logic             zero;
	} alu_rsp_t;

	// Leap test on the year modulo 400.
	function automatic logic is_leap(input logic [8:0] r);
		return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	// Days in month m; zero for a month code that means nothing.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = leap ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	// Days of a common year before the first of month m.
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: design/gda_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module gda_alu (
	input  gda_pkg::alu_req_t req,
	output gda_pkg::alu_rsp_t rsp
);
	import gda_pkg::*;

	logic [ALU_W:0] sum;

	// Subtract as add of the complement plus one; carry out clear means borrow.
	assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
	           + {{ALU_W{1'b0}}, req.sub};

	assign rsp.res    = sum[ALU_W-1:0];
	assign rsp.borrow = req.sub & ~sum[ALU_W];
	assign rsp.zero   = (sum[ALU_W-1:0] == '0);

endmodule

`default_nettype wire

FILE: design/gregorian_date_add_days_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Gregorian date plus a count of days. A start date (day, month, year) and a
// day count come in as one beat; one beat goes out with the date that lies that
// many days later, or with bad_date set and a zero date when the start day or
// month is not valid for that year. Years are proleptic (year 0 is a leap year)
// and end_year carries the low 14 bits of the exact result year. One item is
// handled at a time: in_stall stays high from acceptance until the result is
// loaded into the output register, which may still wait on out_stall while the
// next beat is taken. The subtractions and the ordinal sum run through one
// shared add/subtract unit under a small sequencer, one step per cycle: up to
// 41 steps to reduce the start year modulo 400, one step to form the ordinal,
// one step per year crossed (up to about 2900 for a 20-bit count), and up to
// 12 month steps.
module gregorian_date_add_days_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic [4:0]                   start_day,
	input  wire logic [3:0]                   start_month,
	input  wire logic [13:0]                  start_year,
	input  wire logic [gda_pkg::ADD_BITS-1:0] days_to_add,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic [4:0]                   end_day,
	output      logic [3:0]                   end_month,
	output      logic [13:0]                  end_year,
	output      logic                         bad_date
);
	import gda_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_CHECK,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [4:0]          day_q;
	logic [3:0]          month_q;
	logic [Y_W-1:0]      year_q;
	logic [ADD_BITS-1:0] add_q;
	logic [ALU_W-1:0]    t_q;      // year residue during reduction, then ordinal
	logic [8:0]          res400_q; // year modulo 400
	logic                bad_q;
	logic                out_valid_q;
	logic [4:0]          end_day_q;
	logic [3:0]          end_month_q;
	logic [13:0]         end_year_q;
	logic                end_bad_q;

	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;

	logic                leap;
	logic [4:0]          dim;
	logic [8:0]          ylen;
	logic [8:0]          start_ord;
	logic                start_bad;
	logic                out_free;

	gda_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Leap flag and month length always refer to the year being worked on.
	assign leap = is_leap(res400_q);
	assign dim  = month_days(month_q, leap);
	assign ylen = leap ? LEN_LEAP : LEN_COMMON;

	// Start date checks and its ordinal within the year.
	assign start_bad = (month_q == 4'd0) || (month_q > MONTH_DEC) || (day_q == 5'd0)
	                || (day_q > dim);
	assign start_ord = days_before(month_q) + 9'(day_q)
	                 + 9'((month_q > MONTH_FEB) && leap);

	assign out_free = !out_valid_q || !out_stall;

	// Steer the shared unit by sequencer state.
	always_comb begin
		alu_req.a   = t_q;
		alu_req.b   = '0;
		alu_req.sub = 1'b1;
		case (state_q)
			ST_MOD:   alu_req.b = ALU_W'(CYCLE_YEARS);
			ST_CHECK: begin
				alu_req.a   = ALU_W'(add_q);
				alu_req.b   = ALU_W'(start_ord);
				alu_req.sub = 1'b0;
			end
			ST_YEAR:  alu_req.b = ALU_W'(ylen);
			ST_MONTH: alu_req.b = ALU_W'(dim);
			default:  alu_req.b = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the output beat once taken; in ST_DONE the reload decides.
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					// Capture the beat; reduce the year from its raw value.
					if (in_valid) begin
						day_q   <= start_day;
						month_q <= start_month;
						year_q  <= Y_W'(start_year);
						add_q   <= days_to_add;
						t_q     <= ALU_W'(start_year);
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					// Subtract 400 until it would go negative.
					if (alu_rsp.borrow) begin
						res400_q <= t_q[8:0];
						state_q  <= ST_CHECK;
					end else begin
						t_q <= alu_rsp.res;
					end
				end
				ST_CHECK: begin
					// Validate, then form ordinal plus count.
					bad_q <= start_bad;
					t_q   <= alu_rsp.res;
					if (start_bad) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					// Advance whole years while the ordinal overruns this one.
					if (!alu_rsp.borrow && !alu_rsp.zero) begin
						t_q      <= alu_rsp.res;
						year_q   <= year_q + 1'b1;
						res400_q <= (res400_q == LAST_RES) ? 9'd0 : res400_q + 9'd1;
					end else begin
						month_q <= MONTH_JAN;
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					// Advance months until the ordinal fits; December takes the rest.
					if ((month_q == MONTH_DEC) || alu_rsp.borrow || alu_rsp.zero) begin
						state_q <= ST_DONE;
					end else begin
						t_q     <= alu_rsp.res;
						month_q <= month_q + 4'd1;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free, then load it.
					if (out_free) begin
						out_valid_q <= 1'b1;
						end_day_q   <= bad_q ? 5'd0 : t_q[4:0];
						end_month_q <= bad_q ? 4'd0 : month_q;
						end_year_q  <= bad_q ? 14'd0 : year_q[13:0];
						end_bad_q   <= bad_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign end_day   = end_day_q;
	assign end_month = end_month_q;
	assign end_year  = end_year_q;
	assign bad_date  = end_bad_q;

	// Year residue stays inside one 400-year cycle once reduced.
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR || state_q == ST_MONTH) |-> (res400_q < CYCLE_YEARS))
		else $error("year residue out of range");

	// Month walk stays within January..December.
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH) |-> (month_q >= MONTH_JAN && month_q <= MONTH_DEC))
		else $error("month iterator out of range");

	// An error beat carries a zero date.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_bad_q) |-> (end_day_q == 5'd0 && end_month_q == 4'd0
		                                && end_year_q == 14'd0))
		else $error("error beat with nonzero date");

	// A good beat carries a real day and month.
	a_good_date: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !end_bad_q) |-> (end_day_q != 5'd0 && end_month_q != 4'd0
		                                 && end_month_q <= MONTH_DEC))
		else $error("good beat with impossible date");

endmodule

`default_nettype wire

FILE: tb/sv/date_add_checker.sv
`timescale 1ns / 1ps

// Watch both channels of the date adder and predict each result beat.
module date_add_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [4:0]                   start_day,
	input  logic [3:0]                   start_month,
	input  logic [13:0]                  start_year,
	input  logic [gda_pkg::ADD_BITS-1:0] days_to_add,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [4:0]                   end_day,
	input  logic [3:0]                   end_month,
	input  logic [13:0]                  end_year,
	input  logic                         bad_date,
	output int                           mismatches,
	output int                           waiting,
	output int                           checked,
	output int                           bad_seen
);

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic        bad;
	} date_result_t;

	localparam int unsigned MONTH_LEN [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned DAYS_AHEAD [1:12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	date_result_t pending_dates[$];

	initial begin
		mismatches = 0;
		waiting    = 0;
		checked    = 0;
		bad_seen   = 0;
	end

	function automatic bit leap_gregorian(input int unsigned yr);
		return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
	endfunction

	function automatic int unsigned month_span(input int unsigned mo, input int unsigned yr);
		if (mo == gda_pkg::MONTH_FEB && leap_gregorian(yr))
			return 29;
		return MONTH_LEN[mo];
	endfunction

	function automatic int unsigned year_span(input int unsigned yr);
		return leap_gregorian(yr) ? 366 : 365;
	endfunction

	// Date that lies n days after d/m/y, or a flagged zero date.
	function automatic date_result_t date_after(input logic [4:0] d, input logic [3:0] m,
			input logic [13:0] y, input logic [gda_pkg::ADD_BITS-1:0] n);
		date_result_t r;
		int unsigned yr;
		int unsigned ord;
		int unsigned cnt;
		int unsigned mo;
		r   = '0;
		yr  = 32'(y);
		cnt = 32'(n);
		if (m < gda_pkg::MONTH_JAN || m > gda_pkg::MONTH_DEC) begin
			r.bad = 1'b1;
			return r;
		end
		if (d == 0 || d > month_span(32'(m), yr)) begin
			r.bad = 1'b1;
			return r;
		end
		ord = DAYS_AHEAD[m] + 32'(d);
		if (m > gda_pkg::MONTH_FEB && leap_gregorian(yr))
			ord++;
		if (cnt <= year_span(yr) - ord) begin
			ord += cnt;
		end else begin
			cnt -= year_span(yr) - ord;
			yr++;
			// strict compare: landing on the last day stays in that year
			while (cnt > year_span(yr)) begin
				cnt -= year_span(yr);
				yr++;
			end
			ord = cnt;
		end
		mo = 32'(gda_pkg::MONTH_JAN);
		while (mo < gda_pkg::MONTH_DEC && ord > month_span(mo, yr)) begin
			ord -= month_span(mo, yr);
			mo++;
		end
		r.day   = ord[4:0];
		r.month = mo[3:0];
		r.year  = yr[13:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		date_result_t want;
		if (arst_n) begin
			// retire the result beat before taking in a new date
			if (out_valid && !out_stall) begin
				if (pending_dates.size() == 0) begin
					report_mismatch("result beat with no date pending", int'(bad_date), 0);
				end else begin
					want = pending_dates.pop_front();
					checked++;
					if (bad_date)
						bad_seen++;
					if (end_day !== want.day)
						report_mismatch("end_day", int'(end_day), int'(want.day));
					if (end_month !== want.month)
						report_mismatch("end_month", int'(end_month), int'(want.month));
					if (end_year !== want.year)
						report_mismatch("end_year", int'(end_year), int'(want.year));
					if (bad_date !== want.bad)
						report_mismatch("bad_date", int'(bad_date), int'(want.bad));
				end
			end
			if (in_valid && !in_stall)
				pending_dates.push_back(date_after(start_day, start_month, start_year,
					days_to_add));
			waiting = pending_dates.size();
		end
	end

endmodule

FILE: tb/sv/tb_gregorian_date_add_days_core.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the date adder. The checker beside the block
// predicts every result beat; this module only drives beats and decides.
module tb_gregorian_date_add_days_core;

	localparam int ADD_W       = gda_pkg::ADD_BITS;
	localparam int RANDOM_DATES = 200;
	// Worst item: ~2900 year steps plus year reduction, month steps, gaps and
	// receiver stalls; take the slowest run several times over.
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 100;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_SQUARE,
		STALL_HEAVY
	} stall_mode_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [4:0]       start_day;
	logic [3:0]       start_month;
	logic [13:0]      start_year;
	logic [ADD_W-1:0] days_to_add;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [4:0]       end_day;
	logic [3:0]       end_month;
	logic [13:0]      end_year;
	logic             bad_date;

	int mismatches;
	int waiting;
	int checked;
	int bad_seen;
	int cycle_count = 0;
	int beats_sent  = 0;
	int burst_left  = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	logic [7:0]  stall_tick = '0;

	gregorian_date_add_days_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_day   (start_day),
		.start_month (start_month),
		.start_year  (start_year),
		.days_to_add (days_to_add),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.end_day     (end_day),
		.end_month   (end_month),
		.end_year    (end_year),
		.bad_date    (bad_date)
	);

	date_add_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_day   (start_day),
		.start_month (start_month),
		.start_year  (start_year),
		.days_to_add (days_to_add),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.end_day     (end_day),
		.end_month   (end_month),
		.end_year    (end_year),
		.bad_date    (bad_date),
		.mismatches  (mismatches),
		.waiting     (waiting),
		.checked     (checked),
		.bad_seen    (bad_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Stop a hung run; the block is far too slow only if something is broken.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d dates still pending", cycle_count, waiting);
		$display("tb_gregorian_date_add_days_core: errors");
		$finish;
	end

	// Receiver: switch between stall styles at random intervals so that
	// stalls land both on idle stretches and on the cycle a result appears.
	always @(negedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		if (mode_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left  <= $urandom_range(50, 400);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_SQUARE: out_stall <= stall_tick[2];
			default:      out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// Drive one beat from a falling edge and hold it until taken. Open a new
	// burst after a random gap when the current one runs out.
	task automatic send_beat(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
			input logic [ADD_W-1:0] n);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 10);
		end
		in_valid    = 1'b1;
		start_day   = d;
		start_month = m;
		start_year  = y;
		days_to_add = n;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		@(negedge clk);
		burst_left--;
		beats_sent++;
	endtask

	initial begin
		logic [4:0]       d;
		logic [3:0]       m;
		logic [13:0]      y;
		logic [ADD_W-1:0] n;
		int               pick;
		int               directed;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		start_day   = '0;
		start_month = '0;
		start_year  = '0;
		days_to_add = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, leap rules, invalid dates, year end, wrap.
		send_beat(5'd1, 4'd1, 14'd1, '0);
		send_beat(5'd31, 4'd12, 14'd9999, '0);
		send_beat(5'd31, 4'd12, 14'd9999, ADD_W'(1));
		send_beat(5'd1, 4'd1, 14'd0, '0);
		send_beat(5'd29, 4'd2, 14'd0, '0);          // year zero counts as leap
		send_beat(5'd29, 4'd2, 14'd2000, ADD_W'(365));
		send_beat(5'd29, 4'd2, 14'd1900, '0);       // century, not leap: bad day
		send_beat(5'd29, 4'd2, 14'd2023, '0);
		send_beat(5'd30, 4'd2, 14'd2024, '0);
		send_beat(5'd31, 4'd4, 14'd2024, '0);       // past the end of a 30-day month
		send_beat(5'd0, 4'd6, 14'd2024, ADD_W'(10));   // day zero
		send_beat(5'd15, 4'd0, 14'd2024, ADD_W'(10));  // month zero
		send_beat(5'd15, 4'd13, 14'd2024, ADD_W'(10)); // month past December
		send_beat(5'd31, 4'd15, 14'd16383, '1);     // every input bit high
		send_beat(5'd1, 4'd1, 14'd2023, ADD_W'(364));   // lands on the last day of the year
		send_beat(5'd31, 4'd12, 14'd2023, ADD_W'(366)); // exactly one leap year later
		send_beat(5'd1, 4'd1, 14'd2024, ADD_W'(365));
		send_beat(5'd28, 4'd2, 14'd2100, ADD_W'(1));
		send_beat(5'd28, 4'd2, 14'd2000, ADD_W'(1));
		send_beat(5'd1, 4'd1, 14'd1, '1);           // longest year walk
		send_beat(5'd1, 4'd1, 14'd16383, ADD_W'(1));
		send_beat(5'd31, 4'd12, 14'd16383, ADD_W'(1)); // year wraps to zero
		send_beat(5'd10, 4'd7, 14'd16000, '1);
		send_beat(5'd31, 4'd1, 14'd2024, ADD_W'(29));
		send_beat(5'd14, 4'd10, 14'd1582, ADD_W'(100));
		directed = beats_sent;

		// Random: mostly well-formed dates, some year-end hits, some noise.
		for (int i = 0; i < RANDOM_DATES; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				d = 5'($urandom());
				m = 4'($urandom());
				y = 14'($urandom());
				n = ADD_W'($urandom());
			end else if (pick < 18) begin
				d = 5'd1;
				m = gda_pkg::MONTH_JAN;
				y = 14'($urandom_range(0, 9999));
				n = ADD_W'($urandom_range(364, 365));
			end else begin
				m = 4'($urandom_range(1, 12));
				d = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(28, 31))
				                                : 5'($urandom_range(1, 28));
				pick = $urandom_range(0, 99);
				if (pick < 70)
					y = 14'($urandom_range(1, 9999));
				else if (pick < 85)
					y = 14'($urandom_range(0, 16383));
				else
					y = 14'($urandom_range(15800, 16383));
				// keep most counts short so the year walk stays cheap
				pick = $urandom_range(0, 99);
				if (pick < 55)
					n = ADD_W'($urandom_range(0, 800));
				else if (pick < 85)
					n = ADD_W'($urandom_range(0, 65535));
				else
					n = ADD_W'($urandom());
			end
			send_beat(d, m, y, n);
		end
		in_valid = 1'b0;

		// Drain: wait for every predicted date, then watch for stray beats.
		wait (waiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d beats (%0d directed), %0d results checked, %0d flagged bad",
			beats_sent, directed, checked, bad_seen);
		if (mismatches == 0)
			$display("tb_gregorian_date_add_days_core: clean");
		else
			$display("tb_gregorian_date_add_days_core: errors");
		$finish;
	end

endmodule
